[sv/bfsu_pkg.sv]
package bfsu_pkg;

    localparam int IN_W  = 32;
    localparam int APB_W = 32;
    localparam int CAP_W = 5;
    localparam int ADDR_W = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET     = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_UPDATE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    push;
        logic    pop;
        logic    load;
        logic    scan_step;
        logic    write_back;
        logic    res_valid;
        status_t res_status;
        logic    res_hit;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic issue_done;
        logic cmp_valid;
        logic cmp_hit;
        logic cmp_last;
        logic is_update;
    } dp_stat_t;

endpackage

[sv/bfsu_ctrl.sv]
module bfsu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  bfsu_pkg::dp_stat_t stat,
    output bfsu_pkg::dp_cmd_t  cmd,
    output logic               busy
);
    import bfsu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action_t'(action)) inside
                        ACT_INSERT:
                        begin
                            cmd.res_valid = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push       = 1'b1;
                                cmd.res_status = ST_OK;
                            end
                        end
                        ACT_DELETE:
                        begin
                            cmd.res_valid = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop        = 1'b1;
                                cmd.res_status = ST_OK;
                            end
                        end
                        ACT_SEARCH, ACT_UPDATE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_valid  = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.load   = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (stat.cmp_valid && stat.cmp_hit)
                begin
                    // first match wins: report it and drop the scan
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_hit    = !stat.is_update;
                    cmd.write_back = stat.is_update;
                    state_next     = S_IDLE;
                end
                else if (stat.cmp_valid && stat.cmp_last)
                begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.scan_step = !stat.issue_done;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    a_scan_no_queue_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (!cmd.push && !cmd.pop && !cmd.load))
        else $error("queue moved during a scan");

    a_result_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && cmd.res_valid) |=> (state_reg == S_IDLE))
        else $error("scan did not end after its result");

    a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && cmd.load) |=> (state_reg == S_SCAN))
        else $error("load did not start a scan");
`endif

endmodule

[sv/bfsu_datapath.sv]
module bfsu_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bfsu_pkg::CAP_W-1:0]          capacity,
    input  logic [1:0]                          action,
    input  logic signed [bfsu_pkg::IN_W-1:0]    value,
    input  logic signed [bfsu_pkg::IN_W-1:0]    new_value,
    input  bfsu_pkg::dp_cmd_t                   cmd,
    output bfsu_pkg::dp_stat_t                  stat,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [CNT_W-1:0]                    position,
    output logic [CNT_W-1:0]                    entry_count
);
    import bfsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [PTR_W-1:0]      head_reg;
    logic [PTR_W-1:0]      tail_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [PTR_W-1:0]      scan_idx_reg;
    logic [CNT_W-1:0]      issued_reg;
    logic                  cmp_valid_reg;
    logic [CNT_W-1:0]      cmp_pos_reg;
    logic [PTR_W-1:0]      cmp_slot_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] repl_reg;
    logic                  upd_reg;
    logic                  done_reg;
    status_t               status_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      res_count_reg;

    logic [2*IN_W-1:0]     value_ext;
    logic [2*IN_W-1:0]     new_value_ext;
    logic [DATA_WIDTH-1:0] value_d;
    logic [DATA_WIDTH-1:0] new_value_d;
    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    // sign-extend the input words, keep the stored width
    assign value_ext     = {{IN_W{value[IN_W-1]}}, value};
    assign new_value_ext = {{IN_W{new_value[IN_W-1]}}, new_value};
    assign value_d       = value_ext[DATA_WIDTH-1:0];
    assign new_value_d   = new_value_ext[DATA_WIDTH-1:0];

    assign count_next = count_reg + CNT_W'(cmd.push) - CNT_W'(cmd.pop);

    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(DEPTH))
                             || (CMP_W'(count_reg) >= CMP_W'(capacity));
    assign stat.issue_done = (issued_reg == count_reg);
    assign stat.cmp_valid  = cmp_valid_reg;
    assign stat.cmp_hit    = (rd_data_reg == key_reg);
    assign stat.cmp_last   = (cmp_pos_reg == count_reg);
    assign stat.is_update  = upd_reg;

    assign mem_we    = cmd.push || cmd.write_back;
    assign mem_waddr = cmd.write_back ? cmp_slot_reg : tail_reg;
    assign mem_wdata = cmd.write_back ? repl_reg : value_d;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            issued_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                tail_reg <= ring_next(tail_reg);
            end
            if (cmd.pop)
            begin
                head_reg <= ring_next(head_reg);
            end
            count_reg <= count_next;
            if (cmd.load)
            begin
                scan_idx_reg <= head_reg;
                issued_reg   <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= ring_next(scan_idx_reg);
                issued_reg   <= issued_reg + CNT_W'(1);
            end
            cmp_valid_reg <= cmd.scan_step;
            done_reg      <= cmd.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= value_d;
            repl_reg <= new_value_d;
            upd_reg  <= (action_t'(action) == ACT_UPDATE);
        end
        if (cmd.scan_step)
        begin
            cmp_pos_reg  <= issued_reg + CNT_W'(1);
            cmp_slot_reg <= scan_idx_reg;
        end
        if (cmd.res_valid)
        begin
            status_reg    <= cmd.res_status;
            pos_reg       <= cmd.res_hit ? cmp_pos_reg : '0;
            res_count_reg <= count_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = pos_reg;
    assign entry_count = res_count_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> ((cmp_pos_reg != '0) && (cmp_pos_reg <= count_reg)))
        else $error("scan compared past the live entries");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.full)
        else $error("push into a full queue");
`endif

endmodule

[sv/bounded_fifo_search_update.sv]
// Bounded FIFO of signed words held in a ring store, with search and in-place update.
// Request channel: pulse start with action, value and new_value while busy is low;
// the word is taken at that edge. Actions: insert at tail, delete head, search for
// the first equal entry, update the first equal entry with new_value.
// Result channel: done is high for exactly one cycle with status, position and
// entry_count (entries after the request); the receiver cannot hold it off.
// Insert and delete, and any request on an empty queue: done is registered at the
// accepting edge, busy stays low, so a new request may follow in the next cycle.
// Search and update walk the live entries from the head through the single read
// port of the entry store, one entry per cycle into a registered read word that is
// compared with the key; the first match, or the last entry with no match, ends the
// walk with done, and busy is high while the walk runs.
// Configuration: APB register capacity at byte address 0 (5 bits, reset 16),
// saturated at DEPTH; write it only while the block is idle. pready is always high.
// Reset (rst_n, asynchronous, active low) empties the queue and restores capacity;
// the entry store itself is not cleared, as only written entries are ever read.
module bounded_fifo_search_update #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfsu_pkg::ADDR_W-1:0]       paddr,
    input  logic [bfsu_pkg::APB_W-1:0]        pwdata,
    output logic [bfsu_pkg::APB_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              start,
    input  logic [1:0]                        action,
    input  logic signed [bfsu_pkg::IN_W-1:0]  value,
    input  logic signed [bfsu_pkg::IN_W-1:0]  new_value,
    output logic                              busy,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [$clog2(DEPTH + 1)-1:0]      position,
    output logic [$clog2(DEPTH + 1)-1:0]      entry_count
);
    import bfsu_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    // register write on the access phase
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write && (paddr == ADDR_CAPACITY))
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // read back: capacity at its address, zero elsewhere
    assign prdata = (paddr == ADDR_CAPACITY) ? APB_W'(capacity_reg) : '0;

    bfsu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    bfsu_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .action      (action),
        .value       (value),
        .new_value   (new_value),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

endmodule
